/* rtl/core/vpid_pkg.sv */
// vpid_pkg: shared widths, register indexes, types and width helpers for the
// velocity PID controller. No dependencies.
`default_nettype none

package vpid_pkg;

    localparam int FRAC_BITS_DEF      = 16;
    localparam int STEP_FRAC_BITS_DEF = 20;

    localparam int VEL_W      = 32;
    localparam int ERR_W      = 33;
    localparam int DE_W       = 34;
    localparam int TS_W       = 20;
    localparam int GAIN_W     = 32;
    localparam int LIM_W      = 31;
    localparam int ILIM_W     = 47;
    localparam int TERM_W     = 47;
    localparam int INTEG_W    = 48;
    localparam int PD_W       = 49;
    localparam int SUM_W      = 50;
    localparam int MUL_B_W    = 48;
    localparam int DIGIT_W    = 8;
    localparam int ACC_W      = GAIN_W + MUL_B_W;
    localparam int TORQUE_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 47;
    localparam int S_TDATA_W  = 88;
    localparam int M_TDATA_W  = 32;

    localparam logic [TERM_W-1:0] TERM_MAX = '1;
    localparam logic [ILIM_W-1:0] ILIM_RST = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_KP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TLIM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ILIM = 3'd4;

    typedef enum logic {
        MDU_MUL,
        MDU_DIV
    } mdu_op_t;

    // DIV divides the previous product, shifted up by the step fraction bits
    typedef struct packed {
        logic                 start;
        mdu_op_t              op;
        logic [GAIN_W-1:0]    a;
        logic [MUL_B_W-1:0]   b;
    } mdu_req_t;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
        logic [LIM_W-1:0]  tlim;
        logic [ILIM_W-1:0] ilim;
    } cfg_t;

    typedef struct packed {
        logic             op;
        logic [VEL_W-1:0] target;
        logic [VEL_W-1:0] measured;
        logic [TS_W-1:0]  ts;
    } item_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } ctrl_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_P,
        ST_DMUL,
        ST_DDIV,
        ST_INC,
        ST_ICL,
        ST_ICAND,
        ST_CHK,
        ST_IFIN,
        ST_DONE
    } ctrl_state_t;

    function automatic int div_width(input int sfb);
        return GAIN_W + DE_W + sfb;
    endfunction

    function automatic int res_width(input int sfb);
        return (div_width(sfb) > ACC_W) ? div_width(sfb) : ACC_W;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/velocity_pid_antiwindup.sv */
// velocity_pid_antiwindup: velocity PID with conditional-integration anti-windup; config
// registers, stream ports and output register. Depends on vpid_pkg and vpid_ctrl.
// A new word is accepted only while the controller is idle, one word at a time. A
// nonzero step runs the (66 + STEP_FRAC_BITS)-step radix-2 divide and the multiplies
// of the shared unit; a zero step skips the derivative and the integral increment.
// Reset (aresetn low, synchronous): gains and limits zero, integral limit max, state cleared.
`default_nettype none

module velocity_pid_antiwindup import vpid_pkg::*; #(
    parameter int FRAC_BITS      = FRAC_BITS_DEF,
    parameter int STEP_FRAC_BITS = STEP_FRAC_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // target_velocity[31:0], measured_velocity[63:32], time_step[83:64], zero pad
    input  logic [S_TDATA_W-1:0]    s_tdata,
    // op: 0 compute, 1 clear integral and previous error
    input  logic                    s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // torque_command[31:0]
    output logic [M_TDATA_W-1:0]    m_tdata,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    cfg_t                  cfg_reg;
    item_t                 item;
    ctrl_stat_t            stat;
    logic [TORQUE_W-1:0]   torque;
    logic                  start;
    logic                  out_free;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = stat.idle;
    assign start     = s_tvalid && stat.idle;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign item      = '{op: s_tuser,
                         target: s_tdata[VEL_W-1:0],
                         measured: s_tdata[2*VEL_W-1:VEL_W],
                         ts: s_tdata[2*VEL_W +: TS_W]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{kp: '0, ki: '0, kd: '0, tlim: '0, ilim: ILIM_RST};
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_KP:   cfg_reg.kp   <= cfg_data[GAIN_W-1:0];
                CFG_KI:   cfg_reg.ki   <= cfg_data[GAIN_W-1:0];
                CFG_KD:   cfg_reg.kd   <= cfg_data[GAIN_W-1:0];
                CFG_TLIM: cfg_reg.tlim <= cfg_data[LIM_W-1:0];
                CFG_ILIM: cfg_reg.ilim <= cfg_data[ILIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    vpid_ctrl #(
        .FRAC_BITS      (FRAC_BITS),
        .STEP_FRAC_BITS (STEP_FRAC_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .start    (start),
        .item     (item),
        .out_free (out_free),
        .stat     (stat),
        .torque   (torque)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (stat.res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stat.res_valid) begin
            m_tdata_reg <= torque;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

/* rtl/core/vpid_mdu.sv */
// vpid_mdu: shared multiply / divide unit. Multiply is radix-256 shift-add,
// divide is restoring radix-2. Depends on vpid_pkg.
`default_nettype none

module vpid_mdu import vpid_pkg::*; #(
    parameter int STEP_FRAC_BITS = STEP_FRAC_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  mdu_req_t                                req,
    output logic                                    done,
    output logic [res_width(STEP_FRAC_BITS)-1:0]    res
);

    localparam int DIV_W     = div_width(STEP_FRAC_BITS);
    localparam int RES_W     = res_width(STEP_FRAC_BITS);
    localparam int CNT_W     = $clog2(RES_W + 1);
    localparam int MUL_STEPS = MUL_B_W / DIGIT_W;
    localparam int PROD_W    = GAIN_W + DE_W;

    logic                      busy_reg, busy_next;
    logic                      done_reg;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    mdu_op_t                   op_reg, op_next;
    logic [GAIN_W-1:0]         a_reg, a_next;
    logic [ACC_W-1:0]          acc_reg, acc_next;
    logic [RES_W-1:0]          sh_reg, sh_next;
    logic [TS_W-1:0]           rem_reg, rem_next;
    logic [DIGIT_W-1:0]        digit;
    logic [GAIN_W+DIGIT_W-1:0] pp;
    logic [TS_W:0]             trial;
    logic [TS_W:0]             dvsr;
    logic                      qbit;

    always_comb begin
        digit    = sh_reg[MUL_B_W-1 -: DIGIT_W];
        pp       = a_reg * digit;
        trial    = {rem_reg, sh_reg[DIV_W-1]};
        dvsr     = {1'b0, a_reg[TS_W-1:0]};
        qbit     = (trial >= dvsr);
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        a_next    = a_reg;
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        if (busy_reg) begin
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = (cnt_reg != CNT_W'(1));
            case (op_reg)
                MDU_MUL: begin
                    acc_next = (acc_reg << DIGIT_W) + ACC_W'(pp);
                    sh_next  = sh_reg << DIGIT_W;
                end
                MDU_DIV: begin
                    rem_next = qbit ? TS_W'(trial - dvsr) : trial[TS_W-1:0];
                    sh_next  = {sh_reg[RES_W-2:0], qbit};
                end
                default: begin
                    busy_next = 1'b0;
                end
            endcase
        end else if (req.start) begin
            busy_next = 1'b1;
            op_next   = req.op;
            a_next    = req.a;
            rem_next  = '0;
            if (req.op == MDU_MUL) begin
                cnt_next = CNT_W'(MUL_STEPS);
                acc_next = '0;
                sh_next  = RES_W'(req.b);
            end else begin
                cnt_next = CNT_W'(DIV_W);
                sh_next  = RES_W'({acc_reg[PROD_W-1:0], {STEP_FRAC_BITS{1'b0}}});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg  <= op_next;
        a_reg   <= a_next;
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign res  = (op_reg == MDU_MUL) ? RES_W'(acc_reg) : RES_W'(sh_reg[DIV_W-1:0]);

endmodule

`default_nettype wire

/* rtl/core/vpid_ctrl.sv */
// vpid_ctrl: sequencer, controller state and term datapath around the shared
// multiply / divide unit. Depends on vpid_pkg and vpid_mdu.
`default_nettype none

module vpid_ctrl import vpid_pkg::*; #(
    parameter int FRAC_BITS      = FRAC_BITS_DEF,
    parameter int STEP_FRAC_BITS = STEP_FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfg_t                  cfg,
    input  logic                  start,
    input  item_t                 item,
    input  logic                  out_free,
    output ctrl_stat_t            stat,
    output logic [TORQUE_W-1:0]   torque
);

    localparam int RES_W = res_width(STEP_FRAC_BITS);

    ctrl_state_t           state_reg, state_next;
    logic [ERR_W-1:0]      err_reg, err_next;
    logic [ERR_W-1:0]      last_reg, last_next;
    logic [TS_W-1:0]       ts_reg, ts_next;
    logic [INTEG_W-1:0]    integ_reg, integ_next;
    logic [INTEG_W-1:0]    cand_reg, cand_next;
    logic                  de_neg_reg, de_neg_next;
    logic [PD_W-1:0]       pd_reg, pd_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;

    mdu_req_t              mreq;
    logic                  mdone;
    logic [RES_W-1:0]      mres;

    logic [ERR_W-1:0]      err_in;
    logic [ERR_W-1:0]      err_mag;
    logic [DE_W-1:0]       de;
    logic [DE_W-1:0]       de_mag;
    logic [INTEG_W-1:0]    integ_mag;
    logic [INTEG_W-1:0]    cand_mag;
    logic [INTEG_W-1:0]    inc;
    logic [SUM_W-1:0]      cand_raw;
    logic [SUM_W-1:0]      ilim_pos, ilim_neg;
    logic [SUM_W-1:0]      lim_pos, lim_neg;
    logic [INTEG_W-1:0]    term;
    logic                  term_neg;
    logic                  err_neg, err_pos;
    logic                  further;

    function automatic logic [INTEG_W-1:0] sat_term(input logic [RES_W-1:0] r,
                                                    input logic neg);
        logic [RES_W-1:0]   m;
        logic [TERM_W-1:0]  t;
        m = r >> FRAC_BITS;
        t = (|m[RES_W-1:TERM_W]) ? TERM_MAX : m[TERM_W-1:0];
        return neg ? (~{1'b0, t} + INTEG_W'(1)) : {1'b0, t};
    endfunction

    vpid_mdu #(
        .STEP_FRAC_BITS (STEP_FRAC_BITS)
    ) u_mdu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .done    (mdone),
        .res     (mres)
    );

    always_comb begin
        err_in    = {item.target[VEL_W-1], item.target}
                  - {item.measured[VEL_W-1], item.measured};
        err_neg   = err_reg[ERR_W-1];
        err_pos   = !err_reg[ERR_W-1] && (|err_reg);
        err_mag   = err_neg ? (~err_reg + ERR_W'(1)) : err_reg;
        de        = {err_reg[ERR_W-1], err_reg} - {last_reg[ERR_W-1], last_reg};
        de_mag    = de[DE_W-1] ? (~de + DE_W'(1)) : de;
        integ_mag = integ_reg[INTEG_W-1] ? (~integ_reg + INTEG_W'(1)) : integ_reg;
        cand_mag  = cand_reg[INTEG_W-1] ? (~cand_reg + INTEG_W'(1)) : cand_reg;
        inc       = mres[STEP_FRAC_BITS +: INTEG_W];
        cand_raw  = err_neg
                  ? {{2{integ_reg[INTEG_W-1]}}, integ_reg} - SUM_W'(inc)
                  : {{2{integ_reg[INTEG_W-1]}}, integ_reg} + SUM_W'(inc);
        ilim_pos  = SUM_W'(cfg.ilim);
        ilim_neg  = ~ilim_pos + SUM_W'(1);
        lim_pos   = SUM_W'(cfg.tlim);
        lim_neg   = ~lim_pos + SUM_W'(1);
        case (state_reg)
            ST_P:     term_neg = err_neg;
            ST_DDIV:  term_neg = de_neg_reg;
            ST_ICAND: term_neg = cand_reg[INTEG_W-1];
            default:  term_neg = integ_reg[INTEG_W-1];
        endcase
        term      = sat_term(mres, term_neg);
        further   = (($signed(sum_reg) > $signed(lim_pos)) && err_pos)
                  || (($signed(sum_reg) < $signed(lim_neg)) && err_neg);
        if ($signed(sum_reg) > $signed(lim_pos)) begin
            torque = lim_pos[TORQUE_W-1:0];
        end else if ($signed(sum_reg) < $signed(lim_neg)) begin
            torque = lim_neg[TORQUE_W-1:0];
        end else begin
            torque = sum_reg[TORQUE_W-1:0];
        end
    end

    always_comb begin
        state_next  = state_reg;
        err_next    = err_reg;
        last_next   = last_reg;
        ts_next     = ts_reg;
        integ_next  = integ_reg;
        cand_next   = cand_reg;
        de_neg_next = de_neg_reg;
        pd_next     = pd_reg;
        sum_next    = sum_reg;
        mreq        = '{start: 1'b0, op: MDU_MUL, a: '0, b: '0};
        stat        = '{idle: 1'b0, res_valid: 1'b0};
        case (state_reg)
            ST_IDLE: begin
                stat.idle = 1'b1;
                if (start) begin
                    if (item.op) begin
                        integ_next = '0;
                        last_next  = '0;
                    end else begin
                        err_next   = err_in;
                        ts_next    = item.ts;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                mreq       = '{start: 1'b1, op: MDU_MUL, a: cfg.kp, b: MUL_B_W'(err_mag)};
                state_next = ST_P;
            end
            ST_P: begin
                if (mdone) begin
                    pd_next = {term[INTEG_W-1], term};
                    if (ts_reg == '0) begin
                        cand_next  = integ_reg;
                        state_next = ST_ICL;
                    end else begin
                        de_neg_next = de[DE_W-1];
                        mreq = '{start: 1'b1, op: MDU_MUL, a: cfg.kd, b: MUL_B_W'(de_mag)};
                        state_next = ST_DMUL;
                    end
                end
            end
            ST_DMUL: begin
                if (mdone) begin
                    mreq = '{start: 1'b1, op: MDU_DIV, a: GAIN_W'(ts_reg), b: '0};
                    state_next = ST_DDIV;
                end
            end
            ST_DDIV: begin
                if (mdone) begin
                    pd_next = pd_reg + {term[INTEG_W-1], term};
                    mreq = '{start: 1'b1, op: MDU_MUL, a: GAIN_W'(ts_reg),
                             b: MUL_B_W'(err_mag)};
                    state_next = ST_INC;
                end
            end
            ST_INC: begin
                if (mdone) begin
                    if ($signed(cand_raw) > $signed(ilim_pos)) begin
                        cand_next = ilim_pos[INTEG_W-1:0];
                    end else if ($signed(cand_raw) < $signed(ilim_neg)) begin
                        cand_next = ilim_neg[INTEG_W-1:0];
                    end else begin
                        cand_next = cand_raw[INTEG_W-1:0];
                    end
                    state_next = ST_ICL;
                end
            end
            ST_ICL: begin
                mreq       = '{start: 1'b1, op: MDU_MUL, a: cfg.ki, b: MUL_B_W'(cand_mag)};
                state_next = ST_ICAND;
            end
            ST_ICAND: begin
                if (mdone) begin
                    sum_next   = {pd_reg[PD_W-1], pd_reg} + {{2{term[INTEG_W-1]}}, term};
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                last_next = err_reg;
                if (!further) begin
                    integ_next = cand_reg;
                    state_next = ST_DONE;
                end else begin
                    mreq = '{start: 1'b1, op: MDU_MUL, a: cfg.ki,
                             b: MUL_B_W'(integ_mag)};
                    state_next = ST_IFIN;
                end
            end
            ST_IFIN: begin
                if (mdone) begin
                    sum_next   = {pd_reg[PD_W-1], pd_reg} + {{2{term[INTEG_W-1]}}, term};
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    stat.res_valid = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            integ_reg <= '0;
            last_reg  <= '0;
        end else begin
            state_reg <= state_next;
            integ_reg <= integ_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        err_reg    <= err_next;
        ts_reg     <= ts_next;
        cand_reg   <= cand_next;
        de_neg_reg <= de_neg_next;
        pd_reg     <= pd_next;
        sum_reg    <= sum_next;
    end

endmodule

`default_nettype wire
